/* sv/mexp_pkg.sv */
// Shared types, constants and the modular add-and-reduce step for the
// modular exponentiation core. No dependencies.
package mexp_pkg;

  localparam int DATA_W       = 32;
  localparam int EXP_BITS_DEF = 63;
  localparam logic [DATA_W-1:0] MODULUS_RST = 32'd998244353;

  // multiplier bits consumed per cycle by one modmul unit
  localparam int BITS_PER_CYC = 2;

  localparam int PC_W = 3;

  // wait selects: the step holds while its wait condition is true
  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_IN   = 2'd1;
  localparam logic [1:0] W_UNIT = 2'd2;
  localparam logic [1:0] W_OUT  = 2'd3;

  // branch selects, taken when the step completes
  localparam logic [1:0] B_NEXT     = 2'd0;
  localparam logic [1:0] B_ALWAYS   = 2'd1;
  localparam logic [1:0] B_EXP_ZERO = 2'd2;
  localparam logic [1:0] B_MORE     = 2'd3;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_RED    = 3'd1;
  localparam logic [PC_W-1:0] PC_RED_WB = 3'd2;
  localparam logic [PC_W-1:0] PC_SQ     = 3'd3;
  localparam logic [PC_W-1:0] PC_SQ_WB  = 3'd4;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd5;

  typedef struct packed {
    logic              rdy;
    logic              ld;
    logic              st_red;
    logic              st_sq;
    logic              wb_base;
    logic              wb_both;
    logic              push;
    logic [1:0]        wait_sel;
    logic [1:0]        br_sel;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic in_rdy;
    logic ld;
    logic st_red;
    logic st_sq;
    logic wb_base;
    logic wb_both;
    logic push;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic unit_busy;
    logic out_full;
    logic exp_zero;
    logic exp_more;
  } stat_t;

  // one step of interleaved modmul: (2*acc + mbit*a) mod m, acc and a below m
  function automatic logic [DATA_W-1:0] mm_step(input logic [DATA_W-1:0] acc,
                                                input logic              mbit,
                                                input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] m);
    logic [DATA_W+1:0] t;
    logic [DATA_W+1:0] m1;
    logic [DATA_W+1:0] m2;
    t  = {1'b0, acc, 1'b0} + {2'b00, (mbit ? a : {DATA_W{1'b0}})};
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    priority if (t >= m2) begin
      t = t - m2;
    end else if (t >= m1) begin
      t = t - m1;
    end else begin
      t = t;
    end
    return t[DATA_W-1:0];
  endfunction

endpackage

/* sv/mexp_mulmod.sv */
// Iterative modular multiplier: opa * opb mod modulus, two multiplier bits
// per cycle, MSB first. Depends on mexp_pkg.
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] opa,
  input  logic [DATA_W-1:0] opb,
  input  logic [DATA_W-1:0] modulus,
  output logic              busy,
  output logic [DATA_W-1:0] result
);

  localparam int DIGITS = DATA_W / BITS_PER_CYC;
  localparam int CNT_W  = $clog2(DIGITS);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] mul_r, mul_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;

  always_comb begin
    logic [DATA_W-1:0] t;
    t        = acc_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mul_nxt  = mul_r;
    a_nxt    = a_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mul_nxt  = opb;
      a_nxt    = opa;
    end else if (busy_r) begin
      t = acc_r;
      for (int i = 0; i < BITS_PER_CYC; i++) begin
        t = mm_step(t, mul_r[DATA_W-1-i], a_r, modulus);
      end
      acc_nxt = t;
      mul_nxt = mul_r << BITS_PER_CYC;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIGITS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mul_r <= mul_nxt;
    a_r   <= a_nxt;
  end

  assign busy   = busy_r;
  assign result = acc_r;

endmodule

/* sv/mexp_seq.sv */
// Microcode sequencer: program ROM, step counter, wait and branch logic.
// Depends on mexp_pkg.
module mexp_seq
  import mexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uw;
  logic            hold;

  function automatic ucode_t rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{rdy: 1'b0, ld: 1'b0, st_red: 1'b0, st_sq: 1'b0, wb_base: 1'b0,
          wb_both: 1'b0, push: 1'b0, wait_sel: W_NONE, br_sel: B_ALWAYS,
          target: PC_IDLE};
    unique case (pc)
      PC_IDLE: begin
        w.rdy = 1'b1; w.ld = 1'b1; w.wait_sel = W_IN; w.br_sel = B_NEXT;
      end
      PC_RED: begin
        w.st_red = 1'b1; w.br_sel = B_NEXT;
      end
      PC_RED_WB: begin
        w.wb_base = 1'b1; w.wait_sel = W_UNIT;
        w.br_sel = B_EXP_ZERO; w.target = PC_FINISH;
      end
      PC_SQ: begin
        w.st_sq = 1'b1; w.br_sel = B_NEXT;
      end
      PC_SQ_WB: begin
        w.wb_both = 1'b1; w.wait_sel = W_UNIT;
        w.br_sel = B_MORE; w.target = PC_SQ;
      end
      PC_FINISH: begin
        w.push = 1'b1; w.wait_sel = W_OUT; w.br_sel = B_ALWAYS; w.target = PC_IDLE;
      end
      default: begin
        w.br_sel = B_ALWAYS; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  assign uw = rom(pc_r);

  always_comb begin
    unique case (uw.wait_sel)
      W_NONE:  hold = 1'b0;
      W_IN:    hold = !stat.in_valid;
      W_UNIT:  hold = stat.unit_busy;
      W_OUT:   hold = stat.out_full;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (!hold) begin
      unique case (uw.br_sel)
        B_NEXT:     pc_nxt = pc_r + 1'b1;
        B_ALWAYS:   pc_nxt = uw.target;
        B_EXP_ZERO: pc_nxt = stat.exp_zero ? uw.target : pc_r + 1'b1;
        B_MORE:     pc_nxt = stat.exp_more ? uw.target : pc_r + 1'b1;
        default:    pc_nxt = PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.in_rdy  = uw.rdy;
  assign ctrl.ld      = uw.ld      & !hold;
  assign ctrl.st_red  = uw.st_red  & !hold;
  assign ctrl.st_sq   = uw.st_sq   & !hold;
  assign ctrl.wb_base = uw.wb_base & !hold;
  assign ctrl.wb_both = uw.wb_both & !hold;
  assign ctrl.push    = uw.push    & !hold;

endmodule

/* sv/modular_exponentiation_core.sv */
// Modular exponentiation core: base^exponent mod modulus by square and multiply.
// Top level; depends on mexp_pkg, mexp_seq and mexp_mulmod.
//
// Usage:
//   in_*  : base and exponent in one item (tvalid/tready). in_tready is high
//           only while the core is idle; one item is worked at a time.
//   out_* : one result item per input item, held in an output register
//           until out_tready; the next input item may be taken meanwhile.
//   cfg_* : cfg_wr_en writes cfg_wr_data to the modulus (reset 998244353).
//           Write only while idle. A modulus of zero yields zero.
// Timing: two modmul units (multiply and square) run side by side, each
//   working at two multiplier bits per cycle. The base is reduced first by
//   one product; then one square-and-multiply step follows for each exponent
//   bit up to the highest set bit (none for a zero exponent). The next item
//   is taken only after the previous result has gone to the output register.
// Reset: synchronous, active low; sequencer returns to idle, result
//   register empties, modulus returns to its default.
// Stall: a finished result waits in the output register; the core holds in
//   its last program step until the register is free.
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int EXP_BITS = EXP_BITS_DEF,
  localparam int IN_W = ((DATA_W + EXP_BITS + 7) / 8) * 8
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // base[31:0], exponent, zero pad
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // power_result[31:0]
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data
);

  ctrl_t ctrl;
  stat_t stat;

  logic [DATA_W-1:0]   modulus_r;
  logic [DATA_W-1:0]   base_r, base_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [DATA_W-1:0]   raw_r, raw_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  logic [DATA_W-1:0] one_mod;
  logic              ua_start, ub_start, ua_busy, ub_busy;
  logic [DATA_W-1:0] ua_opa, ua_opb, ua_res, ub_res;

  assign one_mod = (modulus_r <= DATA_W'(1)) ? '0 : DATA_W'(1);

  mexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign ua_start = ctrl.st_red | ctrl.st_sq;
  assign ub_start = ctrl.st_sq;
  assign ua_opa   = ctrl.st_red ? one_mod : base_r;
  assign ua_opb   = ctrl.st_red ? raw_r   : acc_r;

  mexp_mulmod u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ua_start),
    .opa     (ua_opa),
    .opb     (ua_opb),
    .modulus (modulus_r),
    .busy    (ua_busy),
    .result  (ua_res)
  );

  mexp_mulmod u_sqr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ub_start),
    .opa     (base_r),
    .opb     (base_r),
    .modulus (modulus_r),
    .busy    (ub_busy),
    .result  (ub_res)
  );

  assign stat.in_valid  = in_tvalid;
  assign stat.unit_busy = ua_busy | ub_busy;
  assign stat.out_full  = out_valid_r & !out_tready;
  assign stat.exp_zero  = (exp_r == '0);
  assign stat.exp_more  = ((exp_r >> 1) != '0);

  always_comb begin
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    raw_nxt       = raw_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctrl.ld) begin
      raw_nxt = in_tdata[DATA_W-1:0];
      exp_nxt = in_tdata[DATA_W +: EXP_BITS];
      acc_nxt = one_mod;
    end
    if (ctrl.wb_base) begin
      base_nxt = ua_res;
    end
    if (ctrl.wb_both) begin
      if (exp_r[0]) begin
        acc_nxt = ua_res;
      end
      base_nxt = ub_res;
      exp_nxt  = exp_r >> 1;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (modulus_r == '0) ? '0 : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MODULUS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    exp_r      <= exp_nxt;
    raw_r      <= raw_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = ctrl.in_rdy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_push_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> (!ua_busy && !ub_busy))
    else $error("result pushed while a modmul unit is busy");

  a_accept_once: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after an accepted item");

  a_wb_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wb_both |-> (exp_r != '0))
    else $error("square-multiply writeback with exhausted exponent");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((modulus_r == '0) || (out_data_r < modulus_r)))
    else $error("result not reduced below modulus");

  a_units_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ub_start |-> !ua_busy && !ub_busy)
    else $error("modmul restarted while busy");
`endif

endmodule

/* tb/sv/modular_exponentiation_core_tb.sv */
// Testbench for modular_exponentiation_core: streams base/exponent items, predicts
// base^exponent mod modulus in a scoreboard and checks every result item in order.
// Depends on mexp_pkg and the core RTL.
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] base;
  logic [62:0] expo;
  logic [31:0] power;
} power_item_t;

class power_scoreboard;
  logic [31:0] modulus;
  power_item_t pending_q[$];
  int          errors;

  function new();
    modulus = mexp_pkg::MODULUS_RST;
    errors  = 0;
  endfunction

  function logic [31:0] expected_power(logic [31:0] base, logic [62:0] expo);
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] sq;
    int          i;
    m = {32'd0, modulus};
    if (m == 64'd0) begin
      return 32'd0;
    end
    acc = 64'd1 % m;
    sq  = {32'd0, base} % m;
    for (i = 0; i < 63; i++) begin
      if (expo[i]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
    end
    return acc[31:0];
  endfunction

  function void note_operands(logic [31:0] base, logic [62:0] expo);
    power_item_t it;
    it.base  = base;
    it.expo  = expo;
    it.power = expected_power(base, expo);
    pending_q = {pending_q, it};
  endfunction

  function void check_power(logic [31:0] actual);
    power_item_t it;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: result item %0d with no item pending", actual);
      end
      return;
    end
    it = pending_q.pop_front();
    if (actual !== it.power) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: base=%0d exp=%0d mod=%0d expected %0d got %0d",
                 it.base, it.expo, modulus, it.power, actual);
      end
    end
  endfunction
endclass

module modular_exponentiation_core_tb;
  import mexp_pkg::*;

  localparam int EXP_W      = EXP_BITS_DEF;
  localparam int IN_W       = ((DATA_W + EXP_W + 7) / 8) * 8;
  localparam int LONG_HOLD  = 3000;
  localparam int TAIL_WAIT  = 1200;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;

  bit no_idle = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;

  power_scoreboard sb = new();

  modular_exponentiation_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end else begin
      return $urandom_range(30, 120);
    end
  endfunction

  function automatic logic [31:0] rand_base(logic [31:0] m);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return $urandom;
    end else if (r < 65) begin
      return $urandom_range(0, 3);
    end else if (r < 80) begin
      return m + $urandom_range(0, 4) - 32'd2;
    end else if (r < 92) begin
      return $urandom_range(0, m);
    end else begin
      return 32'hFFFF_FFFF - $urandom_range(0, 3);
    end
  endfunction

  // mostly short exponents; full-width ones now and then
  function automatic logic [62:0] rand_exponent();
    int unsigned r;
    int          len;
    logic [63:0] full;
    logic [62:0] e;
    r    = $urandom_range(0, 99);
    full = {$urandom, $urandom};
    if (r < 5) begin
      return '0;
    end else if (r < 15) begin
      return full[62:0];
    end else if (r < 18) begin
      return '1;
    end
    len = $urandom_range(1, 12);
    e = full[62:0] & ((63'd1 << len) - 63'd1);
    e[len-1] = 1'b1;
    return e;
  endfunction

  task automatic send_item(input logic [31:0] base, input logic [62:0] expo);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-DATA_W-EXP_W){1'b0}}, expo, base};
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.note_operands(base, expo);
  endtask

  task automatic idle_in(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.modulus = value;
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_power(out_tdata);
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        out_tready <= (stall == 0);
        if (stall > 0) begin
          stall--;
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] phase_mod [9];
    int          p;
    int          n;
    int          count;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default modulus: zero exponent, zero/max base, base equal to modulus,
    // single-bit and alternating exponents
    send_item(32'd0, 63'd0);
    send_item(32'd0, 63'd5);
    send_item(32'hFFFF_FFFF, 63'd1);
    send_item(32'hFFFF_FFFF, '1);
    send_item(MODULUS_RST, 63'd3);
    send_item(MODULUS_RST - 32'd1, 63'h4000_0000_0000_0000);
    send_item(32'd1, '1);
    send_item(32'd2, 63'd62);
    send_item(32'd3, 63'd1);
    send_item($urandom, 63'd0);
    send_item(32'h8000_0000, 63'h5555_5555_5555_5555);
    send_item(32'h7FFF_FFFF, 63'h2AAA_AAAA_AAAA_AAAA);
    send_item(32'd123456789, 63'd998244351);
    wait_idle();

    phase_mod[0] = MODULUS_RST;
    phase_mod[1] = 32'd2;
    phase_mod[2] = 32'hFFFF_FFFF;
    phase_mod[3] = 32'd1;
    phase_mod[4] = 32'd0;
    phase_mod[5] = $urandom | 32'h8000_0001;
    phase_mod[6] = $urandom_range(3, 65535);
    phase_mod[7] = 32'h8000_0000;
    phase_mod[8] = MODULUS_RST;

    for (p = 0; p < 9; p++) begin
      if (p > 0) begin
        write_modulus(phase_mod[p]);
      end
      no_idle = (p == 2) || (p == 6);
      count = (phase_mod[p] < 32'd2) ? 50 : 200;
      for (n = 0; n < count; n++) begin
        if (p == 1 && n == 20) begin
          hold_requests++;
        end
        send_item(rand_base(phase_mod[p]), rand_exponent());
        idle_in(no_idle ? 0 : gap_len());
      end
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("modular_exponentiation_core_tb: PASS");
    end else begin
      $display("modular_exponentiation_core_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("modular_exponentiation_core_tb: FAIL");
    $finish;
  end

endmodule
